// ===== hdl/pmeter_pkg.sv =====
// ----------------------------------------------------------------------------
// pmeter_pkg: shared constants and types of the PWM period and duty meter
// Register map, result limits, scaling constants and queue status.
// ----------------------------------------------------------------------------
`default_nettype none

package pmeter_pkg;

	// APB register map
	localparam int unsigned APB_DATA_W  = 32;
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned REG_IDX_W   = 1;
	localparam logic [REG_IDX_W-1:0] REG_TIMER_CLOCK = 1'b0;

	// timer clock register
	localparam int unsigned CLOCK_W = 27;
	localparam logic [CLOCK_W-1:0] CLOCK_RESET = 27'd16000000;

	// result field widths and limits
	localparam int unsigned PERIOD_OUT_W = 16;
	localparam int unsigned FREQ_W       = 17;
	localparam int unsigned DUTY_W       = 7;
	localparam int unsigned CELLS_W      = 4;
	localparam logic [FREQ_W-1:0]  FREQ_MAX  = 17'd131071;
	localparam logic [DUTY_W-1:0]  DUTY_FULL = 7'd100;
	localparam logic [CELLS_W-1:0] CELLS_MAX = 4'd15;

	// scaling constants
	localparam int unsigned KHZ_SCALE = 1000;
	localparam int unsigned PCT_SCALE = 100;
	// floor(x / 100) == (x * 5243) >> 19 for every x up to 100 * 32 bar cells
	localparam int unsigned CELL_RECIP = 5243;
	localparam int unsigned CELL_SHIFT = 19;

	// measurement queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ===== hdl/pwm_period_duty_meter.sv =====
// ----------------------------------------------------------------------------
// pwm_period_duty_meter: PWM period, frequency and duty meter
// Measures rise-to-rise period and high time of a sampled PWM signal and
// reports period, frequency in kHz, duty percent and display bar cells.
// ----------------------------------------------------------------------------
// Each accepted input beat is one timer tick carrying the sampled PWM level;
// a free-running COUNTER_BITS-wide counter advances once per accepted beat
// and timestamps a rising edge, the following falling edge and the next
// rising edge, after which one result beat is produced and measurement
// restarts at the next fresh rising edge. The capture front takes one tick
// per cycle unless in_stall is high. Completed measurements wait in a
// two-entry queue for the arithmetic back end, which runs a
// shared restoring divider one quotient bit per cycle: first
// timer_clock_hz / (period * 1000), then high * 100 / period, each over
// max(27, COUNTER_BITS + 7) steps, and a measurement is popped only once
// the last result is in the output register. A zero period skips the
// divider. in_stall rises only while the queue is full, so ticks flow
// every cycle as long as measured periods average longer than the back-end
// time. Frequency saturates at 131071, duty at 100 and bar cells at 15.
// The timer clock register sits at byte address 0 of the APB port and must
// be written only while no measurement is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_period_duty_meter import pmeter_pkg::*; #(
	parameter int unsigned COUNTER_BITS = 16,
	parameter int unsigned BAR_CELLS    = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// tick input
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    pwm_level,
	// result output
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [PERIOD_OUT_W-1:0]      period_ticks,
	output logic [FREQ_W-1:0]            freq_khz,
	output logic [DUTY_W-1:0]            duty_percent,
	output logic [CELLS_W-1:0]           high_cells,
	output logic                         period_zero,
	// configuration
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [APB_ADDR_W-1:0]   paddr,
	input  wire logic [APB_DATA_W-1:0]   pwdata,
	output logic [APB_DATA_W-1:0]        prdata,
	output logic                         pready
);

	localparam int unsigned CB = COUNTER_BITS;

	logic [CLOCK_W-1:0]  clock_hz_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                tick;
	logic                meas_push;
	logic [CB-1:0]       meas_period;
	logic [CB-1:0]       meas_high;
	logic [2*CB-1:0]     q_rd_data;
	logic                q_pop;
	q_status_t           q_stat;

	// ---------------------------------------------------------------- APB
	// Decode on word address; pready is tied high, so every access is
	// zero-wait.
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];
	assign prdata  = (reg_idx == REG_TIMER_CLOCK) ? APB_DATA_W'(clock_hz_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_TIMER_CLOCK) begin
			clock_hz_q <= pwdata[CLOCK_W-1:0];
		end
	end

	// ---------------------------------------------------------------- front
	// Hold off ticks while the queue cannot take a finished measurement.
	assign in_stall = q_stat.full;
	assign tick     = in_valid && !in_stall;

	pmeter_front #(
		.CB (CB)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.pwm_level (pwm_level),
		.push      (meas_push),
		.period    (meas_period),
		.high      (meas_high)
	);

	// ---------------------------------------------------------------- queue
	pmeter_queue #(
		.DATA_W (2 * CB)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (meas_push),
		.wr_data ({meas_period, meas_high}),
		.pop     (q_pop),
		.rd_data (q_rd_data),
		.status  (q_stat)
	);

	// ---------------------------------------------------------------- back
	pmeter_back #(
		.CB        (CB),
		.BAR_CELLS (BAR_CELLS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.clock_hz     (clock_hz_q),
		.q_avail      (!q_stat.empty),
		.q_period     (q_rd_data[2*CB-1:CB]),
		.q_high       (q_rd_data[CB-1:0]),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.period_ticks (period_ticks),
		.freq_khz     (freq_khz),
		.duty_percent (duty_percent),
		.high_cells   (high_cells),
		.period_zero  (period_zero)
	);

	// ---------------------------------------------------------------- checks
	// A zero period forces every other field to zero.
	a_zero_period_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && period_zero |->
			period_ticks == '0 && freq_khz == '0 && duty_percent == '0 && high_cells == '0)
		else $error("zero-period result carries nonzero fields");

	// Duty never exceeds full scale.
	a_duty_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty_percent <= DUTY_FULL)
		else $error("duty percent above 100");

	// Full duty lights every bar cell, up to the field limit.
	a_full_duty_cells: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !period_zero && duty_percent == DUTY_FULL |->
			(high_cells == CELLS_W'(BAR_CELLS) || high_cells == CELLS_MAX))
		else $error("bar cells wrong at full duty");

	// Queue status is never full and empty at once.
	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

endmodule

`default_nettype wire

// ===== hdl/pmeter_front.sv =====
// ----------------------------------------------------------------------------
// pmeter_front: tick counter and edge capture
// Stamps rise, fall and next rise of the PWM input, then pushes one
// period / high-time pair per completed measurement.
// ----------------------------------------------------------------------------
`default_nettype none

module pmeter_front import pmeter_pkg::*; #(
	parameter int unsigned CB = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tick,
	input  wire logic          pwm_level,
	output logic               push,
	output logic [CB-1:0]      period,
	output logic [CB-1:0]      high
);

	localparam logic [1:0] PH_WAIT_RISE = 2'd0;
	localparam logic [1:0] PH_WAIT_FALL = 2'd1;
	localparam logic [1:0] PH_WAIT_NEXT = 2'd2;

	logic          prev_q;
	logic [1:0]    phase_q;
	logic [CB-1:0] tick_q;
	logic [CB-1:0] rise_q;
	logic [CB-1:0] fall_q;
	logic          rising;
	logic          falling;

	assign rising  = !prev_q && pwm_level;
	assign falling = prev_q && !pwm_level;

	assign push   = tick && (phase_q == PH_WAIT_NEXT) && rising;
	assign period = tick_q - rise_q;
	assign high   = fall_q - rise_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b0;
			phase_q <= PH_WAIT_RISE;
			tick_q  <= '0;
			rise_q  <= '0;
			fall_q  <= '0;
		end else if (tick) begin
			prev_q <= pwm_level;
			tick_q <= tick_q + CB'(1);
			unique case (phase_q)
				PH_WAIT_FALL: begin
					if (falling) begin
						fall_q  <= tick_q;
						phase_q <= PH_WAIT_NEXT;
					end
				end
				PH_WAIT_NEXT: begin
					// closing edge does not open the next measurement
					if (rising) begin
						phase_q <= PH_WAIT_RISE;
					end
				end
				default: begin
					phase_q <= PH_WAIT_RISE;
					if (rising) begin
						rise_q  <= tick_q;
						phase_q <= PH_WAIT_FALL;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pmeter_queue.sv =====
// ----------------------------------------------------------------------------
// pmeter_queue: short measurement queue
// Small first-in first-out buffer between the capture front and the
// arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none

module pmeter_queue import pmeter_pkg::*; #(
	parameter int unsigned DATA_W = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              pop,
	output logic      [DATA_W-1:0] rd_data,
	output q_status_t              status
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pmeter_back.sv =====
// ----------------------------------------------------------------------------
// pmeter_back: frequency, duty and bar-cell arithmetic
// One shared restoring divider runs the frequency and then the duty
// quotient, one bit per cycle; results go out through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pmeter_back import pmeter_pkg::*; #(
	parameter int unsigned CB        = 16,
	parameter int unsigned BAR_CELLS = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [CLOCK_W-1:0]      clock_hz,
	input  wire logic                    q_avail,
	input  wire logic [CB-1:0]           q_period,
	input  wire logic [CB-1:0]           q_high,
	output logic                         q_pop,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [PERIOD_OUT_W-1:0]      period_ticks,
	output logic [FREQ_W-1:0]            freq_khz,
	output logic [DUTY_W-1:0]            duty_percent,
	output logic [CELLS_W-1:0]           high_cells,
	output logic                         period_zero
);

	localparam int unsigned NUM_W   = (CLOCK_W > CB + 7) ? CLOCK_W : CB + 7;
	localparam int unsigned DIV_W   = CB + 10;
	localparam int unsigned CNT_W   = $clog2(NUM_W + 1);
	localparam int unsigned PEXT_W  = (CB > PERIOD_OUT_W) ? CB : PERIOD_OUT_W;
	localparam int unsigned CELL_MUL = BAR_CELLS * CELL_RECIP;
	localparam int unsigned PROD_W  = $clog2(PCT_SCALE * CELL_MUL + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FREQ = 2'd1;
	localparam logic [1:0] ST_DUTY = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  div_q;
	logic [DIV_W-1:0]  rem_q;
	logic [NUM_W-1:0]  num_q;
	logic [CB-1:0]     period_q;
	logic [CB-1:0]     high_q;
	logic              zero_q;
	logic              full_q;
	logic [NUM_W-1:0]  freq_q;
	logic [DUTY_W-1:0] duty_q;

	logic [DIV_W:0]    trial;
	logic              fits;
	logic [DIV_W:0]    diff;
	logic [DIV_W-1:0]  rem_nxt;
	logic [NUM_W-1:0]  num_nxt;
	logic              last_step;
	logic              slot_free;
	logic [DUTY_W-1:0] duty_fin;
	logic [FREQ_W-1:0] freq_fin;
	logic [PROD_W-1:0] cell_prod;
	logic [PROD_W-1:0] cell_raw;
	logic [CELLS_W-1:0] cells_fin;
	logic [PEXT_W-1:0] period_ext;

	// one restoring division step
	assign trial   = {rem_q, num_q[NUM_W-1]};
	assign fits    = (trial >= {1'b0, div_q});
	assign diff    = trial - {1'b0, div_q};
	assign rem_nxt = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
	assign num_nxt = {num_q[NUM_W-2:0], fits};
	assign last_step = (cnt_q == CNT_W'(1));

	assign q_pop     = (state_q == ST_IDLE) && q_avail;
	assign slot_free = !out_valid || !out_stall;

	// result formatting
	assign freq_fin  = (freq_q > NUM_W'(FREQ_MAX)) ? FREQ_MAX : freq_q[FREQ_W-1:0];
	assign duty_fin  = full_q ? DUTY_FULL : duty_q;
	assign cell_prod = PROD_W'(duty_fin) * PROD_W'(CELL_MUL);
	assign cell_raw  = cell_prod >> CELL_SHIFT;
	assign cells_fin = (cell_raw > PROD_W'(CELLS_MAX)) ? CELLS_MAX : cell_raw[CELLS_W-1:0];
	assign period_ext = PEXT_W'(period_q);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				period_q <= q_period;
				high_q   <= q_high;
				full_q   <= (q_high >= q_period);
				div_q    <= DIV_W'(q_period) * DIV_W'(KHZ_SCALE);
				num_q    <= NUM_W'(clock_hz);
				rem_q    <= '0;
			end
			ST_FREQ: begin
				if (last_step) begin
					freq_q <= num_nxt;
					div_q  <= DIV_W'(period_q);
					num_q  <= NUM_W'(high_q) * NUM_W'(PCT_SCALE);
					rem_q  <= '0;
				end else begin
					num_q <= num_nxt;
					rem_q <= rem_nxt;
				end
			end
			ST_DUTY: begin
				num_q <= num_nxt;
				rem_q <= rem_nxt;
				if (last_step) begin
					duty_q <= num_nxt[DUTY_W-1:0];
				end
			end
			default: begin
				if (slot_free) begin
					period_ticks <= zero_q ? '0 : period_ext[PERIOD_OUT_W-1:0];
					freq_khz     <= zero_q ? '0 : freq_fin;
					duty_percent <= zero_q ? '0 : duty_fin;
					high_cells   <= zero_q ? '0 : cells_fin;
					period_zero  <= zero_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			zero_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// load a new beat when the slot frees, else drop a taken one
			if (state_q == ST_DONE && slot_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_avail) begin
						cnt_q  <= CNT_W'(NUM_W);
						zero_q <= (q_period == '0);
						state_q <= (q_period == '0) ? ST_DONE : ST_FREQ;
					end
				end
				ST_FREQ: begin
					cnt_q <= last_step ? CNT_W'(NUM_W) : cnt_q - CNT_W'(1);
					if (last_step) begin
						state_q <= ST_DUTY;
					end
				end
				ST_DUTY: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				default: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire
